// File: src/sm83alu_pkg.sv
package sm83alu_pkg;

   // flag bit positions in the 4-bit flag nibble
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   localparam logic [7:0] DAA_HI_ADJ = 8'h60;
   localparam logic [7:0] DAA_LO_ADJ = 8'h06;
   localparam logic [7:0] DAA_HI_MAX = 8'h99;
   localparam logic [3:0] DAA_LO_MAX = 4'h9;

   typedef enum logic [4:0] {
      OP_ADD   = 5'd0,
      OP_ADC   = 5'd1,
      OP_SUB   = 5'd2,
      OP_SBC   = 5'd3,
      OP_AND   = 5'd4,
      OP_OR    = 5'd5,
      OP_XOR   = 5'd6,
      OP_CP    = 5'd7,
      OP_ADD16 = 5'd8,
      OP_SPOFF = 5'd9,
      OP_RLCA  = 5'd10,
      OP_RRCA  = 5'd11,
      OP_RLA   = 5'd12,
      OP_RRA   = 5'd13,
      OP_CPL   = 5'd14,
      OP_SCF   = 5'd15,
      OP_CCF   = 5'd16,
      OP_DAA   = 5'd17,
      OP_RLC   = 5'd18,
      OP_RRC   = 5'd19,
      OP_RL    = 5'd20,
      OP_RR    = 5'd21,
      OP_SLA   = 5'd22,
      OP_SRA   = 5'd23,
      OP_SWAP  = 5'd24,
      OP_SRL   = 5'd25
   } op_type;

   typedef enum logic [2:0] {
      CB_RLC  = 3'd0,
      CB_RRC  = 3'd1,
      CB_RL   = 3'd2,
      CB_RR   = 3'd3,
      CB_SLA  = 3'd4,
      CB_SRA  = 3'd5,
      CB_SWAP = 3'd6,
      CB_SRL  = 3'd7
   } cb_sel_type;

   typedef struct packed {
      logic [4:0]        opcode;
      logic [7:0]        acc_in;
      logic [3:0]        flags_in;
      logic [15:0]       operand;
      logic [15:0]       base16;
      logic signed [7:0] offset;
   } req_type;

   typedef struct packed {
      logic [7:0]  acc_out;
      logic [3:0]  flags_out;
      logic [7:0]  result8;
      logic [15:0] result16;
   } rsp_type;

endpackage

// File: src/sm83alu_cb.sv
module sm83alu_cb (
   input  sm83alu_pkg::cb_sel_type sel,
   input  logic [7:0]              data_in,
   input  logic                    carry_in,
   output logic [7:0]              data_out,
   output logic                    carry_out
);
   import sm83alu_pkg::*;

   always_comb begin
      carry_out = data_in[0];
      data_out  = {1'b0, data_in[7:1]};
      case (sel)
         CB_RLC: begin
            carry_out = data_in[7];
            data_out  = {data_in[6:0], data_in[7]};
         end
         CB_RRC: begin
            carry_out = data_in[0];
            data_out  = {data_in[0], data_in[7:1]};
         end
         CB_RL: begin
            carry_out = data_in[7];
            data_out  = {data_in[6:0], carry_in};
         end
         CB_RR: begin
            carry_out = data_in[0];
            data_out  = {carry_in, data_in[7:1]};
         end
         CB_SLA: begin
            carry_out = data_in[7];
            data_out  = {data_in[6:0], 1'b0};
         end
         CB_SRA: begin
            carry_out = data_in[0];
            data_out  = {data_in[7], data_in[7:1]};
         end
         CB_SWAP: begin
            carry_out = 1'b0;
            data_out  = {data_in[3:0], data_in[7:4]};
         end
         CB_SRL: begin
            carry_out = data_in[0];
            data_out  = {1'b0, data_in[7:1]};
         end
         default: begin
            carry_out = data_in[0];
            data_out  = {1'b0, data_in[7:1]};
         end
      endcase
   end

endmodule

// File: src/sm83alu_core.sv
module sm83alu_core (
   input  sm83alu_pkg::req_type req,
   output sm83alu_pkg::rsp_type rsp
);
   import sm83alu_pkg::*;

   op_type      op;
   logic [7:0]  a;
   logic [7:0]  v;
   logic [3:0]  f;
   logic        c_in;
   logic        add_cin;
   logic        sub_cin;
   logic [8:0]  add_sum;
   logic [4:0]  add_lo;
   logic [8:0]  sub_diff;
   logic [4:0]  sub_lo;
   logic [16:0] sum16;
   logic [12:0] sum16_lo;
   logic [15:0] sp_sum;
   logic [4:0]  sp_lo;
   logic [8:0]  sp_byte;
   logic        acc_rot;
   logic [4:0]  cb_idx;
   cb_sel_type  cb_sel;
   logic [7:0]  cb_data;
   logic [7:0]  cb_res;
   logic        cb_carry;
   logic        daa_c;
   logic        daa_l;
   logic [7:0]  daa_add;
   logic [7:0]  daa_sub;
   logic [7:0]  logic_res;

   assign op   = op_type'(req.opcode);
   assign a    = req.acc_in;
   assign v    = req.operand[7:0];
   assign f    = req.flags_in;
   assign c_in = f[FLAG_C];

   assign add_cin  = (op == OP_ADC) && c_in;
   assign sub_cin  = (op == OP_SBC) && c_in;
   assign add_sum  = {1'b0, a} + {1'b0, v} + {8'd0, add_cin};
   assign add_lo   = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, add_cin};
   // bit 8 / bit 4 of the difference is the borrow
   assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, sub_cin};
   assign sub_lo   = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, sub_cin};

   assign sum16    = {1'b0, req.base16} + {1'b0, req.operand};
   assign sum16_lo = {1'b0, req.base16[11:0]} + {1'b0, req.operand[11:0]};

   assign sp_sum  = req.base16 + {{8{req.offset[7]}}, req.offset};
   assign sp_lo   = {1'b0, req.base16[3:0]} + {1'b0, req.offset[3:0]};
   assign sp_byte = {1'b0, req.base16[7:0]} + {1'b0, req.offset};

   // one shift/rotate unit serves both the accumulator rotates and the CB group
   assign acc_rot = (op == OP_RLCA) || (op == OP_RRCA) || (op == OP_RLA) || (op == OP_RRA);
   assign cb_idx  = acc_rot ? (req.opcode - OP_RLCA) : (req.opcode - OP_RLC);
   assign cb_sel  = cb_sel_type'(cb_idx[2:0]);
   assign cb_data = acc_rot ? a : v;

   sm83alu_cb u_cb (
      .sel       (cb_sel),
      .data_in   (cb_data),
      .carry_in  (c_in),
      .data_out  (cb_res),
      .carry_out (cb_carry)
   );

   assign daa_c   = c_in || (a > DAA_HI_MAX);
   assign daa_l   = f[FLAG_H] || (a[3:0] > DAA_LO_MAX);
   assign daa_add = a + (daa_c ? DAA_HI_ADJ : 8'd0) + (daa_l ? DAA_LO_ADJ : 8'd0);
   assign daa_sub = a - (f[FLAG_H] ? DAA_LO_ADJ : 8'd0) - (c_in ? DAA_HI_ADJ : 8'd0);

   always_comb begin
      case (op)
         OP_AND:  logic_res = a & v;
         OP_OR:   logic_res = a | v;
         default: logic_res = a ^ v;
      endcase
   end

   always_comb begin
      rsp.acc_out   = a;
      rsp.flags_out = f;
      rsp.result8   = 8'd0;
      rsp.result16  = 16'd0;
      case (op)
         OP_ADD, OP_ADC: begin
            rsp.acc_out   = add_sum[7:0];
            rsp.flags_out = {add_sum[7:0] == 8'd0, 1'b0, add_lo[4], add_sum[8]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            if (op != OP_CP) begin
               rsp.acc_out = sub_diff[7:0];
            end
            rsp.flags_out = {sub_diff[7:0] == 8'd0, 1'b1, sub_lo[4], sub_diff[8]};
         end
         OP_AND: begin
            rsp.acc_out   = logic_res;
            rsp.flags_out = {logic_res == 8'd0, 1'b0, 1'b1, 1'b0};
         end
         OP_OR, OP_XOR: begin
            rsp.acc_out   = logic_res;
            rsp.flags_out = {logic_res == 8'd0, 3'b000};
         end
         OP_ADD16: begin
            rsp.result16  = sum16[15:0];
            rsp.flags_out = {f[FLAG_Z], 1'b0, sum16_lo[12], sum16[16]};
         end
         OP_SPOFF: begin
            rsp.result16  = sp_sum;
            rsp.flags_out = {2'b00, sp_lo[4], sp_byte[8]};
         end
         OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
            rsp.acc_out   = cb_res;
            rsp.flags_out = {3'b000, cb_carry};
         end
         OP_CPL: begin
            rsp.acc_out   = ~a;
            rsp.flags_out = {f[FLAG_Z], 1'b1, 1'b1, c_in};
         end
         OP_SCF: rsp.flags_out = {f[FLAG_Z], 2'b00, 1'b1};
         OP_CCF: rsp.flags_out = {f[FLAG_Z], 2'b00, !c_in};
         OP_DAA: begin
            if (!f[FLAG_N]) begin
               rsp.acc_out   = daa_add;
               rsp.flags_out = {daa_add == 8'd0, 2'b00, daa_c};
            end else begin
               rsp.acc_out   = daa_sub;
               rsp.flags_out = {daa_sub == 8'd0, 1'b1, 1'b0, c_in};
            end
         end
         OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
            rsp.result8   = cb_res;
            rsp.flags_out = {cb_res == 8'd0, 2'b00, cb_carry};
         end
         default: begin
            rsp.acc_out   = a;
            rsp.flags_out = f;
         end
      endcase
   end

endmodule

// File: src/sm83_alu_flags.sv
// Flow: an accepted request is captured in the input register; its result is
// then taken into the output register unless the result side stalls.
// Throughput: one request per cycle unless stalled; input and result registers
// hold while the result side stalls, so a full pipe of two requests can wait.
// Reset (synchronous, active high) empties both stages; data is not cleared.
module sm83_alu_flags (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sm83alu_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sm83alu_pkg::rsp_type rsp_payload
);
   import sm83alu_pkg::*;

   req_type req_ff;
   req_type req_in;
   logic    req_valid_ff;
   logic    req_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   rsp_type core_rsp;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    out_hold;

   assign out_hold  = rsp_valid_ff && rsp_stall;
   assign req_stall = req_valid_ff && out_hold;

   sm83alu_core u_core (
      .req (req_ff),
      .rsp (core_rsp)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
         if (req_valid) begin
            req_in = req_payload;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (!out_hold) begin
         rsp_valid_in = req_valid_ff;
         if (req_valid_ff) begin
            rsp_in = core_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_valid_ff))
      else $error("result appeared with no request in the input stage");

   a_stage_advances: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !out_hold) |=> rsp_valid_ff)
      else $error("request in input stage was dropped");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_valid_ff)
      else $error("accepted request not captured");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!req_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

import sm83alu_pkg::*;

class alu_scoreboard;
   rsp_type alu_results_q[$];
   int      errors;

   function new();
      errors = 0;
   endfunction

   // {carry out, value} for the shift/rotate group
   function logic [8:0] shift_byte(cb_sel_type sel, logic [7:0] v, logic cin);
      case (sel)
         CB_RLC:  return {v[7], v[6:0], v[7]};
         CB_RRC:  return {v[0], v[0], v[7:1]};
         CB_RL:   return {v[7], v[6:0], cin};
         CB_RR:   return {v[0], cin, v[7:1]};
         CB_SLA:  return {v[7], v[6:0], 1'b0};
         CB_SRA:  return {v[0], v[7], v[7:1]};
         CB_SWAP: return {1'b0, v[3:0], v[7:4]};
         default: return {v[0], 1'b0, v[7:1]};
      endcase
   endfunction

   function rsp_type alu_eval(req_type r);
      rsp_type     o;
      logic [7:0]  a;
      logic [7:0]  v;
      logic [7:0]  s;
      logic [3:0]  f;
      logic        cin;
      logic        dc;
      logic [8:0]  s9;
      logic [4:0]  nib;
      logic [12:0] s13;
      logic [16:0] s17;
      logic [8:0]  cr;
      logic [4:0]  sel5;
      logic [15:0] ext;
      a   = r.acc_in;
      f   = r.flags_in;
      v   = r.operand[7:0];
      cin = f[FLAG_C];
      o.acc_out   = a;
      o.flags_out = f;
      o.result8   = '0;
      o.result16  = '0;
      case (r.opcode)
         OP_ADD, OP_ADC: begin
            if (r.opcode == OP_ADD) cin = 1'b0;
            s9  = {1'b0, a} + {1'b0, v} + cin;
            nib = {1'b0, a[3:0]} + {1'b0, v[3:0]} + cin;
            o.acc_out = s9[7:0];
            o.flags_out = '0;
            o.flags_out[FLAG_Z] = (s9[7:0] == 8'h00);
            o.flags_out[FLAG_H] = nib[4];
            o.flags_out[FLAG_C] = s9[8];
         end
         OP_SUB, OP_SBC, OP_CP: begin
            if (r.opcode != OP_SBC) cin = 1'b0;
            // bit 8 / bit 4 of the wrapped difference is the borrow
            s9  = {1'b0, a} - {1'b0, v} - cin;
            nib = {1'b0, a[3:0]} - {1'b0, v[3:0]} - cin;
            o.flags_out = '0;
            o.flags_out[FLAG_Z] = (s9[7:0] == 8'h00);
            o.flags_out[FLAG_N] = 1'b1;
            o.flags_out[FLAG_H] = nib[4];
            o.flags_out[FLAG_C] = s9[8];
            if (r.opcode != OP_CP) o.acc_out = s9[7:0];
         end
         OP_AND: begin
            o.acc_out = a & v;
            o.flags_out = '0;
            o.flags_out[FLAG_Z] = (o.acc_out == 8'h00);
            o.flags_out[FLAG_H] = 1'b1;
         end
         OP_OR, OP_XOR: begin
            o.acc_out = (r.opcode == OP_OR) ? (a | v) : (a ^ v);
            o.flags_out = '0;
            o.flags_out[FLAG_Z] = (o.acc_out == 8'h00);
         end
         OP_ADD16: begin
            s17 = {1'b0, r.base16} + {1'b0, r.operand};
            s13 = {1'b0, r.base16[11:0]} + {1'b0, r.operand[11:0]};
            o.result16 = s17[15:0];
            o.flags_out = '0;
            o.flags_out[FLAG_Z] = f[FLAG_Z];
            o.flags_out[FLAG_H] = s13[12];
            o.flags_out[FLAG_C] = s17[16];
         end
         OP_SPOFF: begin
            ext = {{8{r.offset[7]}}, r.offset[7:0]};
            o.result16 = r.base16 + ext;
            nib = {1'b0, r.base16[3:0]} + {1'b0, r.offset[3:0]};
            s9  = {1'b0, r.base16[7:0]} + {1'b0, r.offset[7:0]};
            o.flags_out = '0;
            o.flags_out[FLAG_H] = nib[4];
            o.flags_out[FLAG_C] = s9[8];
         end
         OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
            sel5 = r.opcode - OP_RLCA;
            cr = shift_byte(cb_sel_type'(sel5[2:0]), a, cin);
            o.acc_out = cr[7:0];
            o.flags_out = '0;
            o.flags_out[FLAG_C] = cr[8];
         end
         OP_CPL: begin
            o.acc_out = ~a;
            o.flags_out[FLAG_N] = 1'b1;
            o.flags_out[FLAG_H] = 1'b1;
         end
         OP_SCF: begin
            o.flags_out = '0;
            o.flags_out[FLAG_Z] = f[FLAG_Z];
            o.flags_out[FLAG_C] = 1'b1;
         end
         OP_CCF: begin
            o.flags_out = '0;
            o.flags_out[FLAG_Z] = f[FLAG_Z];
            o.flags_out[FLAG_C] = ~cin;
         end
         OP_DAA: begin
            s = a;
            o.flags_out = '0;
            if (!f[FLAG_N]) begin
               dc = cin;
               if (dc || (a > DAA_HI_MAX)) begin
                  s  = s + DAA_HI_ADJ;
                  dc = 1'b1;
               end
               if (f[FLAG_H] || (a[3:0] > DAA_LO_MAX)) s = s + DAA_LO_ADJ;
               o.flags_out[FLAG_C] = dc;
            end else begin
               if (f[FLAG_H]) s = s - DAA_LO_ADJ;
               if (cin) s = s - DAA_HI_ADJ;
               o.flags_out[FLAG_N] = 1'b1;
               o.flags_out[FLAG_C] = cin;
            end
            o.acc_out = s;
            o.flags_out[FLAG_Z] = (s == 8'h00);
         end
         OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
            sel5 = r.opcode - OP_RLC;
            cr = shift_byte(cb_sel_type'(sel5[2:0]), v, cin);
            o.result8 = cr[7:0];
            o.flags_out = '0;
            o.flags_out[FLAG_Z] = (cr[7:0] == 8'h00);
            o.flags_out[FLAG_C] = cr[8];
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function void note_request(req_type r);
      alu_results_q.push_back(alu_eval(r));
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (alu_results_q.size() == 0) begin
         $display("%0t: result with none pending: expected nothing, actual %h", $time, got);
         errors++;
         return;
      end
      want = alu_results_q.pop_front();
      if (got.acc_out !== want.acc_out) begin
         $display("%0t: acc_out expected %h actual %h", $time, want.acc_out, got.acc_out);
         errors++;
      end
      if (got.flags_out !== want.flags_out) begin
         $display("%0t: flags_out expected %b actual %b", $time, want.flags_out,
                  got.flags_out);
         errors++;
      end
      if (got.result8 !== want.result8) begin
         $display("%0t: result8 expected %h actual %h", $time, want.result8, got.result8);
         errors++;
      end
      if (got.result16 !== want.result16) begin
         $display("%0t: result16 expected %h actual %h", $time, want.result16,
                  got.result16);
         errors++;
      end
   endfunction

   function int pending();
      return alu_results_q.size();
   endfunction
endclass

module tb;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         MAX_GAP      = 14;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         PHASE_ITEMS  = 310;
   localparam int         NUM_PHASES   = 5;
   localparam logic [4:0] OP_UNUSED_LO = 5'd26;
   localparam logic [4:0] OP_UNUSED_HI = 5'd31;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   alu_scoreboard sb = new();

   bit tx_no_idle   = 1'b0;
   bit rx_no_idle   = 1'b0;
   bit hold_request = 1'b0;
   int cycles       = 0;

   sm83_alu_flags u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int draw_gap(bit no_idle);
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_type mk_request(logic [4:0] op, logic [7:0] a, logic [3:0] f,
                                          logic [15:0] w, logic [15:0] b, logic [7:0] e);
      req_type r;
      r.opcode   = op;
      r.acc_in   = a;
      r.flags_in = f;
      r.operand  = w;
      r.base16   = b;
      r.offset   = e;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.opcode   = 5'($urandom_range(0, 31));
      r.acc_in   = pick_byte();
      r.flags_in = 4'($urandom_range(0, 15));
      r.operand  = {pick_byte(), pick_byte()};
      if ($urandom_range(0, 7) == 0) r.operand[7:0] = r.acc_in;
      r.base16   = {pick_byte(), pick_byte()};
      r.offset   = pick_byte();
      return r;
   endfunction

   task automatic send_request(req_type r);
      int gap;
      gap = draw_gap(tx_no_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // sender pause: wait until every pending result has come back
   task automatic drain();
      req_valid <= 1'b0;
      // the last accepted request is noted by the monitor at the edge just passed
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
      end
   end

   // result side
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         gap = draw_gap(rx_no_idle);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin
      req_type directed[$];
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(mk_request(OP_ADD,   8'hFF, 4'h0, 16'hFF01, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_ADC,   8'h0F, 4'h1, 16'h0000, 16'hFFFF, 8'hFF));
      directed.push_back(mk_request(OP_SUB,   8'h3C, 4'hF, 16'h003C, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_SBC,   8'h00, 4'h1, 16'h00FF, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_AND,   8'h00, 4'h0, 16'hFFFF, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_OR,    8'h00, 4'hF, 16'hFF00, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_XOR,   8'hFF, 4'h0, 16'h00FF, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_CP,    8'h10, 4'h0, 16'h0001, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_ADD16, 8'h00, 4'h8, 16'h0001, 16'h0FFF, 8'h00));
      directed.push_back(mk_request(OP_ADD16, 8'hFF, 4'h0, 16'hFFFF, 16'hFFFF, 8'h00));
      directed.push_back(mk_request(OP_SPOFF, 8'h00, 4'hF, 16'h0000, 16'h00FF, 8'h7F));
      directed.push_back(mk_request(OP_SPOFF, 8'h00, 4'hF, 16'h0000, 16'h0000, 8'h80));
      directed.push_back(mk_request(OP_RLCA,  8'h80, 4'hE, 16'h0000, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_RRCA,  8'h01, 4'h0, 16'h0000, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_RLA,   8'h80, 4'h0, 16'h0000, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_RRA,   8'h01, 4'h1, 16'h0000, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_CPL,   8'h55, 4'h0, 16'h0000, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_SCF,   8'h00, 4'hE, 16'h0000, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_CCF,   8'h00, 4'h9, 16'h0000, 16'h0000, 8'h00));
      // decimal adjust: add path above 0x99, add path with H and C, subtract path
      directed.push_back(mk_request(OP_DAA,   8'h9A, 4'h0, 16'h0000, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_DAA,   8'h00, 4'h3, 16'h0000, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_DAA,   8'h00, 4'h7, 16'h0000, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_RLC,   8'h00, 4'h0, 16'h0080, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_RRC,   8'h00, 4'h0, 16'h0001, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_RL,    8'h00, 4'h1, 16'h0080, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_RR,    8'h00, 4'h1, 16'h0001, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_SLA,   8'h00, 4'h0, 16'h0080, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_SRA,   8'h00, 4'h0, 16'h0081, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_SWAP,  8'h00, 4'hF, 16'hFF00, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_SRL,   8'h00, 4'h0, 16'h0001, 16'h0000, 8'h00));
      directed.push_back(mk_request(OP_UNUSED_LO, 8'hA5, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF));
      directed.push_back(mk_request(OP_UNUSED_HI, 8'hFF, 4'h5, 16'hFFFF, 16'hFFFF, 8'h80));
      foreach (directed[i]) send_request(directed[i]);
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         tx_no_idle = (phase == 1) || (phase == 2);
         rx_no_idle = (phase == 3);
         // back-pressure: result side holds off while requests keep coming
         if (phase == 2) hold_request = 1'b1;
         repeat (PHASE_ITEMS) send_request(random_request());
         drain();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
